/* rtl/nlms_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nlms_pkg
// Shared constants, controller/datapath command and status words, and the
// saturation helpers of the NLMS adaptive FIR.
// ----------------------------------------------------------------------------
package nlms_pkg;

  localparam int DEF_TAPS = 128;
  localparam logic [23:0] STEP_RESET = 24'd1678;
  // Quotient bits of the weight increment; anything at or above 2^QB
  // saturates the weight regardless of its old value.
  localparam int QB = 32;

  typedef struct packed {
    logic clr;      // write zeros at the sweep index
    logic accept;   // take an input word, shift the delay line
    logic rd;       // read tap and weight at the current index
    logic mul;      // form products of the read tap
    logic acc;      // accumulate and advance
    logic est;      // form estimate and error
    logic mu;       // form mu * error
    logic umul;     // form mu * error * tap
    logic uprep;    // magnitude and divider set-up
    logic div;      // one quotient bit
    logic wb;       // write back the weight and advance
    logic load_out; // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic last_tap;
    logic energy_zero;
    logic div_last;
  } sts_t;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'sh7fff;
    end else if (v < -64'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/nlms_adaptive_fir.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nlms_adaptive_fir
// Normalised LMS adaptive FIR filter, Q1.15 samples, Q2.30 weights.
// ----------------------------------------------------------------------------
// Input words (reference_sample, measured_sample, measured_valid) are taken
// on in_valid && in_ready; one result word (drive_sample, filter_estimate,
// error_sample) follows on out_valid/out_ready for every input word.
// step_size is written on cfg_valid (cfg_ready is always high); the user
// must write it only while idle, as the block itself does not enforce this.
// After reset a clearing sweep zeroes the tap and weight memories; in_ready
// stays low until it ends. step_size resets to 1678. For each item the filter
// pass reads, multiplies and accumulates one tap after another, then the
// estimate and error are formed; the update pass reads each tap and weight,
// forms mu * error * tap, runs the bit-serial divider and writes the weight
// back. With zero tap energy the update pass is skipped.
// The next word can be taken from the cycle after the result is loaded.
// A finished result sits in the output register; the next input word is
// accepted while it waits, and the block stalls only if a second result is
// ready before the first is taken.
// ----------------------------------------------------------------------------
module nlms_adaptive_fir #(
  parameter int TAPS = nlms_pkg::DEF_TAPS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [23:0] step_size,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] reference_sample,
  input  wire logic signed [15:0] measured_sample,
  input  wire logic               measured_valid,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed      [15:0] drive_sample,
  output logic signed      [15:0] filter_estimate,
  output logic signed      [15:0] error_sample
);

  nlms_pkg::cmd_t cmd;
  nlms_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  nlms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nlms_dp #(.TAPS(TAPS)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .step_size        (step_size),
    .reference_sample (reference_sample),
    .measured_sample  (measured_sample),
    .measured_valid   (measured_valid),
    .drive_sample     (drive_sample),
    .filter_estimate  (filter_estimate),
    .error_sample     (error_sample)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_no_update_on_zero_energy: assert property (@(posedge clk) disable iff (rst)
    cmd.wb |-> !sts.energy_zero)
    else $error("weight written back with zero tap energy");

  a_single_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("handshake active straight after reset");

endmodule
`default_nettype wire

/* rtl/nlms_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nlms_ctrl
// Sequencer: clearing sweep after reset, filter pass, estimate, update pass
// with one serial division per tap, and the output handshake.
// ----------------------------------------------------------------------------
module nlms_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire nlms_pkg::sts_t sts,
  output nlms_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_EST   = 4'd5;
  localparam logic [3:0] S_MU    = 4'd6;
  localparam logic [3:0] S_URD   = 4'd7;
  localparam logic [3:0] S_UM1   = 4'd8;
  localparam logic [3:0] S_UM2   = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_WB    = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.last_tap) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = sts.last_tap ? S_EST : S_RD;
      end
      S_EST: begin
        cmd.est    = 1'b1;
        state_next = sts.energy_zero ? S_DONE : S_MU;
      end
      S_MU: begin
        cmd.mu     = 1'b1;
        state_next = S_URD;
      end
      S_URD: begin
        cmd.rd     = 1'b1;
        state_next = S_UM1;
      end
      S_UM1: begin
        cmd.umul   = 1'b1;
        state_next = S_UM2;
      end
      S_UM2: begin
        cmd.uprep  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) state_next = S_WB;
      end
      S_WB: begin
        cmd.wb     = 1'b1;
        state_next = sts.last_tap ? S_DONE : S_URD;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/nlms_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nlms_dp
// Datapath: circular tap memory, weight memory, MAC, estimate and error,
// step register, restoring divider for the normalised update, result words.
// ----------------------------------------------------------------------------
module nlms_dp #(
  parameter int TAPS = nlms_pkg::DEF_TAPS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire nlms_pkg::cmd_t     cmd,
  output nlms_pkg::sts_t          sts,
  input  wire logic               cfg_valid,
  input  wire logic        [23:0] step_size,
  input  wire logic signed [15:0] reference_sample,
  input  wire logic signed [15:0] measured_sample,
  input  wire logic               measured_valid,
  output logic signed      [15:0] drive_sample,
  output logic signed      [15:0] filter_estimate,
  output logic signed      [15:0] error_sample
);

  localparam int IW = $clog2(TAPS);
  localparam int AW = 48 + $clog2(TAPS);
  localparam int EW = 31 + $clog2(TAPS);
  localparam int QB = nlms_pkg::QB;
  localparam int DW = EW + QB;
  localparam int CW = $clog2(QB);
  localparam int MW = 61;
  localparam logic [IW-1:0] LAST = IW'(TAPS - 1);

  logic signed [15:0] tmem [TAPS];
  logic signed [31:0] wmem [TAPS];

  logic [IW-1:0] k, wp, rp, wp_next;
  logic [23:0]   step;
  logic signed [15:0] held, ref_q, tap_q, est_q, err_q;
  logic signed [31:0] w_q;
  logic signed [47:0] prod;
  logic signed [31:0] sq;
  logic signed [AW-1:0] acc;
  logic [EW-1:0]      energy;
  logic signed [40:0] mu_err;
  logic signed [56:0] p;
  logic [56:0]        pa;
  logic [MW-1:0]      mag_c;
  logic               neg, qsat;
  logic [DW-1:0]      rem, dsh;
  logic [QB-1:0]      q;
  logic [CW-1:0]      cnt;
  logic signed [63:0] est_w, diff_w;
  logic [QB:0]        qq;
  logic signed [QB+2:0] d, wsum;
  logic signed [31:0] w_new;

  assign wp_next = (wp == LAST) ? '0 : wp + 1'b1;

  assign est_w  = {{(64-(AW-30)){acc[AW-1]}}, acc[AW-1:30]};
  assign diff_w = {{48{held[15]}}, held} - est_w;

  assign pa    = p[56] ? 57'(-p) : p;
  assign mag_c = {pa[54:0], 6'b0};

  assign qq    = qsat ? {1'b1, {QB{1'b0}}} : {1'b0, q};
  assign d     = neg ? -$signed({2'b00, qq}) : $signed({2'b00, qq});
  assign wsum  = {{(QB-29){w_q[31]}}, w_q} + d;
  assign w_new = nlms_pkg::sat32({{(64-(QB+3)){wsum[QB+2]}}, wsum});

  assign sts.last_tap    = (k == LAST);
  assign sts.energy_zero = (energy == '0);
  assign sts.div_last    = (cnt == CW'(QB - 1));

  // memories
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      tmem[k] <= '0;
    end else if (cmd.accept) begin
      tmem[wp_next] <= reference_sample;
    end
    if (cmd.clr) begin
      wmem[k] <= '0;
    end else if (cmd.wb) begin
      wmem[k] <= w_new;
    end
    if (cmd.rd) begin
      tap_q <= tmem[rp];
      w_q   <= wmem[k];
    end
  end

  // control counters and reset-valued registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k    <= '0;
      wp   <= '0;
      rp   <= '0;
      held <= '0;
      step <= nlms_pkg::STEP_RESET;
      cnt  <= '0;
    end else begin
      if (cfg_valid) step <= step_size;
      if (cmd.accept) begin
        wp <= wp_next;
        rp <= wp_next;
        k  <= '0;
        if (measured_valid) held <= measured_sample;
      end else if (cmd.est) begin
        rp <= wp;
        k  <= '0;
      end else if (cmd.clr || cmd.acc || cmd.wb) begin
        // walk from newest to oldest tap
        k  <= sts.last_tap ? '0 : k + 1'b1;
        rp <= (rp == '0) ? LAST : rp - 1'b1;
      end
      if (cmd.uprep) begin
        cnt <= '0;
      end else if (cmd.div) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // arithmetic
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ref_q  <= reference_sample;
      acc    <= '0;
      energy <= '0;
    end
    if (cmd.mul) begin
      prod <= tap_q * w_q;
      sq   <= tap_q * tap_q;
    end
    if (cmd.acc) begin
      acc    <= acc + {{(AW-48){prod[47]}}, prod};
      energy <= energy + {{(EW-31){1'b0}}, sq[30:0]};
    end
    if (cmd.est) begin
      est_q <= nlms_pkg::sat16(est_w);
      err_q <= nlms_pkg::sat16(diff_w);
    end
    if (cmd.mu) begin
      mu_err <= $signed({1'b0, step}) * err_q;
    end
    if (cmd.umul) begin
      p <= mu_err * tap_q;
    end
    if (cmd.uprep) begin
      neg  <= p[56];
      rem  <= {{(DW-MW){1'b0}}, mag_c};
      dsh  <= {1'b0, energy, {(QB-1){1'b0}}};
      q    <= '0;
      qsat <= ({{(DW-MW){1'b0}}, mag_c} >= {energy, {QB{1'b0}}});
    end
    if (cmd.div) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        q   <= {q[QB-2:0], 1'b1};
      end else begin
        q   <= {q[QB-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
    if (cmd.load_out) begin
      drive_sample    <= ref_q;
      filter_estimate <= est_q;
      error_sample    <= err_q;
    end
  end

endmodule
`default_nettype wire

/* sim/tb_nlms_adaptive_fir.sv */
// ----------------------------------------------------------------------------
// tb_nlms_adaptive_fir
// Self-checking bench for the 128-tap NLMS adaptive FIR. A clocked driver
// feeds sample words from a queue. A fixed-point model of the filter
// predicts each result word when its input word is taken. A clocked monitor
// compares the result words with those predictions. The step size is
// rewritten between phases, from zero to full scale.
// ----------------------------------------------------------------------------
module tb_nlms_adaptive_fir;

  localparam int NTAPS = 128;

  typedef struct {
    logic signed [15:0] ref_s;
    logic signed [15:0] meas_s;
    logic               meas_v;
  } sample_word_t;

  typedef struct {
    logic signed [15:0] drive;
    logic signed [15:0] est;
    logic signed [15:0] err;
  } filter_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [23:0] step_size = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] reference_sample = '0;
  logic signed [15:0] measured_sample = '0;
  logic measured_valid = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] drive_sample, filter_estimate, error_sample;

  sample_word_t pending_words[$];
  filter_word_t expected_words[$];

  // filter model state
  logic signed [15:0] m_taps[NTAPS];
  logic signed [31:0] m_weights[NTAPS];
  logic signed [15:0] m_held;
  logic [23:0]        m_mu;

  int  mismatches = 0;
  int  words_in = 0;
  int  words_out = 0;
  int  hold_cycles = 0;
  bit  hold_done = 1'b0;
  bit  quiet = 1'b0;

  always #5 clk = ~clk;

  nlms_adaptive_fir i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .step_size(step_size),
    .in_valid(in_valid), .in_ready(in_ready),
    .reference_sample(reference_sample), .measured_sample(measured_sample),
    .measured_valid(measured_valid),
    .out_valid(out_valid), .out_ready(out_ready),
    .drive_sample(drive_sample), .filter_estimate(filter_estimate),
    .error_sample(error_sample)
  );

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Shift in one sample, form estimate and error, then adapt the weights unless the tap energy is zero.
  function automatic filter_word_t nlms_update(sample_word_t w);
    filter_word_t r;
    longint acc, energy, est, err, p, mag, q;
    acc = 0;
    energy = 0;
    for (int k = NTAPS - 1; k > 0; k--) m_taps[k] = m_taps[k - 1];
    m_taps[0] = w.ref_s;
    if (w.meas_v) m_held = w.meas_s;
    for (int k = 0; k < NTAPS; k++) begin
      acc += longint'(m_taps[k]) * longint'(m_weights[k]);
      energy += longint'(m_taps[k]) * longint'(m_taps[k]);
    end
    est = acc >>> 30;
    err = clamp(longint'(m_held) - est, -32768, 32767);
    if (energy != 0) begin
      for (int k = 0; k < NTAPS; k++) begin
        p = longint'(m_mu) * err * longint'(m_taps[k]);
        mag = (p < 0 ? -p : p) << 6;
        q = mag / energy;
        m_weights[k] = 32'(clamp(longint'(m_weights[k]) + (p < 0 ? -q : q),
                                 -64'sd2147483648, 64'sd2147483647));
      end
    end
    r.drive = w.ref_s;
    r.est = 16'(clamp(est, -32768, 32767));
    r.err = 16'(err);
    return r;
  endfunction

  // Driver: predict on acceptance, then offer the next word or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_words.push_back(nlms_update('{reference_sample, measured_sample,
                                               measured_valid}));
        words_in++;
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && (quiet || $urandom_range(99) >= 7)) begin
          sample_word_t w;
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          reference_sample <= w.ref_s;
          measured_sample <= w.meas_s;
          measured_valid <= w.meas_v;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long back-pressure: hold the output off once, early in the run.
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && words_in == 60) begin
      hold_cycles <= 20000;
      hold_done <= 1'b1;
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_out++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
        end else begin
          filter_word_t e;
          e = expected_words.pop_front();
          if (e.drive !== drive_sample || e.est !== filter_estimate ||
              e.err !== error_sample) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word %0d: expected drive %0d est %0d err %0d, got %0d %0d %0d",
                       words_out, e.drive, e.est, e.err,
                       drive_sample, filter_estimate, error_sample);
          end
        end
      end
      out_ready <= (hold_cycles == 0) && (quiet || $urandom_range(99) >= 7);
    end
  end

  task automatic write_step(logic [23:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    step_size <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_mu = v;
  endtask

  task automatic add_word(int r, int m, bit v);
    pending_words.push_back('{16'(r), 16'(m), v});
  endtask

  task automatic add_random(int n);
    int amp;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: amp = 200;
        1: amp = 4000;
        default: amp = 32767;
      endcase
      if ($urandom_range(19) == 0)
        add_word($urandom_range(1) ? 32767 : -32768,
                 $urandom_range(1) ? 32767 : -32768, 1'b1);
      else
        add_word($urandom_range(2 * amp) - amp, $urandom_range(65535) - 32768,
                 $urandom_range(3) != 0);
    end
  endtask

  task automatic drain;
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    for (int k = 0; k < NTAPS; k++) begin
      m_taps[k] = '0;
      m_weights[k] = '0;
    end
    m_held = '0;
    m_mu = nlms_pkg::STEP_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: zero energy first, extremes, held measurement
    write_step(nlms_pkg::STEP_RESET);
    add_word(0, 1000, 1'b1);
    add_word(0, -1000, 1'b0);
    add_word(32767, 32767, 1'b1);
    add_word(-32768, -32768, 1'b1);
    add_word(32767, 0, 1'b0);
    add_word(-32768, 32767, 1'b1);
    add_word(1, -32768, 1'b1);
    add_word(-1, 0, 1'b0);
    add_word(0, 12345, 1'b0);
    drain();

    // full-scale step drives the weights into saturation
    write_step(24'hFFFFFF);
    for (int i = 0; i < 8; i++) add_word(i[0] ? -32768 : 32767, 32767, 1'b1);
    add_random(100);
    drain();

    write_step(24'h000000);
    add_random(80);
    drain();

    quiet = 1'b1;
    write_step(24'($urandom_range(24'hFFFFFF)));
    add_random(150);
    drain();
    quiet = 1'b0;

    write_step(nlms_pkg::STEP_RESET);
    add_random(200);
    drain();

    $display("Covered %0d sample words across five step settings, zero to full scale,",
             words_in);
    $display("with one long output stall and %0d result words checked.", words_out);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #300_000_000;
    $display("timeout after %0d of %0d words", words_out, words_in);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
rtl/nlms_pkg.sv
rtl/nlms_ctrl.sv
rtl/nlms_dp.sv
rtl/nlms_adaptive_fir.sv
sim/tb_nlms_adaptive_fir.sv
